[sv/assert_macros.svh]
// Assertion macros shared by the scanner modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: invariant");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[sv/xasp_pkg.sv]
// Shared types, character codes and helpers for the attribute span scanner.
`default_nettype none

package xasp_pkg;

   // Width of document positions and their saturation limit
   localparam int unsigned POS_W = 24;
   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   // Character codes the classifier looks for
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_EQUAL = 8'h3D;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;

   typedef enum logic [1:0] {
      CLS_SPACE,
      CLS_EQUAL,
      CLS_QUOTE,
      CLS_OTHER
   } char_class_type;

   // Per-result control flags carried from front to back
   typedef struct packed {
      logic has_span;
      logic end_of_list;
   } span_flags_type;

   function automatic char_class_type classify(input logic [7:0] code);
      char_class_type cls;
      case (code)
         CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_CR: cls = CLS_SPACE;
         CHAR_EQUAL:                              cls = CLS_EQUAL;
         CHAR_QUOTE:                              cls = CLS_QUOTE;
         default:                                 cls = CLS_OTHER;
      endcase
      return cls;
   endfunction

endpackage

`default_nettype wire

[sv/xml_attribute_span_scanner.sv]
// Top level of the attribute span scanner: front end, event queue, back end.
//
//   channel   direction  handshake              payload
//   req_      in         push / full            char_code, base_position, last_char
//   rsp_      out        empty / pop            has_span, span_start, span_end, end_of_list
//
// One character is taken per cycle while req_full is low; the state machine update in
// the front end is a combinational table, so a new character may follow every cycle.
// A result is held first in the event queue, which takes it at the edge that accepts
// its character, and then in the output register, which loads it from the queue when
// it is free or being drained; from there it is on the rsp_ ports.
// Reset clears the scan state, the queue pointers and count, and the output valid flag; no clearing pass.
// A stalled result side fills the two-entry queue, after which full stops input;
// characters that give no result never occupy the queue.
`default_nettype none

module xml_attribute_span_scanner #(
   parameter int unsigned MAX_BUFFER_LENGTH = 4096
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_push,
   output logic                             req_full,
   input  wire logic [7:0]                  req_char_code,
   input  wire logic [xasp_pkg::POS_W-1:0]  req_base_position,
   input  wire logic                        req_last_char,
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop,
   output logic                             rsp_has_span,
   output logic [xasp_pkg::POS_W-1:0]       rsp_span_start,
   output logic [xasp_pkg::POS_W-1:0]       rsp_span_end,
   output logic                             rsp_end_of_list
);
   import xasp_pkg::*;

   localparam int unsigned IDX_W = $clog2(MAX_BUFFER_LENGTH);
   localparam int unsigned EV_W  = $bits(span_flags_type) + IDX_W + (IDX_W + 1) + POS_W;

   logic             in_accept;
   logic             ev_push, ev_pop, ev_valid;
   span_flags_type   ev_flags, q_flags;
   logic [IDX_W-1:0] ev_start_off, q_start_off;
   logic [IDX_W:0]   ev_end_off, q_end_off;
   logic [POS_W-1:0] q_base;
   logic [EV_W-1:0]  ev_data, q_data;

   assign in_accept = req_push && !req_full;

   xasp_front #(
      .MAX_BUFFER_LENGTH (MAX_BUFFER_LENGTH),
      .IDX_W             (IDX_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_accept    (in_accept),
      .char_code    (req_char_code),
      .last_char    (req_last_char),
      .ev_push      (ev_push),
      .ev_flags     (ev_flags),
      .ev_start_off (ev_start_off),
      .ev_end_off   (ev_end_off)
   );

   // Pack one span event for the queue
   assign ev_data = {ev_flags, ev_start_off, ev_end_off, req_base_position};

   xasp_queue #(
      .WIDTH (EV_W),
      .DEPTH (2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_push),
      .push_data (ev_data),
      .full      (req_full),
      .pop       (ev_pop),
      .valid     (ev_valid),
      .head_data (q_data)
   );

   assign {q_flags, q_start_off, q_end_off, q_base} = q_data;

   xasp_back #(
      .IDX_W (IDX_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .ev_valid        (ev_valid),
      .ev_flags        (q_flags),
      .ev_start_off    (q_start_off),
      .ev_end_off      (q_end_off),
      .ev_base         (q_base),
      .ev_pop          (ev_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_has_span    (rsp_has_span),
      .rsp_span_start  (rsp_span_start),
      .rsp_span_end    (rsp_span_end),
      .rsp_end_of_list (rsp_end_of_list)
   );

endmodule

`default_nettype wire

[sv/xasp_front.sv]
// Front end: character classification and the attribute state machine.
`default_nettype none
`include "assert_macros.svh"

module xasp_front #(
   parameter int unsigned MAX_BUFFER_LENGTH = 4096,
   parameter int unsigned IDX_W = $clog2(MAX_BUFFER_LENGTH)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_accept,
   input  wire logic [7:0]                   char_code,
   input  wire logic                         last_char,
   output logic                              ev_push,
   output xasp_pkg::span_flags_type          ev_flags,
   output logic [IDX_W-1:0]                  ev_start_off,
   output logic [IDX_W:0]                    ev_end_off
);
   import xasp_pkg::*;

   localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(MAX_BUFFER_LENGTH - 1);

   typedef enum logic [2:0] {
      ST_INVALID = 3'd0,
      ST_KEY     = 3'd1,
      ST_PRE     = 3'd2,
      ST_ASSIGN  = 3'd3,
      ST_STRING  = 3'd4,
      ST_VALUE   = 3'd5
   } scan_state_type;

   scan_state_type   state_ff, state_in, st_cur, st_next;
   logic [IDX_W-1:0] key_offset_ff, key_offset_in, key_next;
   logic [IDX_W-1:0] char_index_ff, char_index_in;
   char_class_type   cls;
   logic             done, tail, has;

   // Transition table for one character
   always_comb begin
      cls = classify(char_code);
      unique case (state_ff)
         ST_INVALID, ST_KEY, ST_PRE, ST_ASSIGN, ST_STRING, ST_VALUE: st_cur = state_ff;
         default: st_cur = ST_INVALID;
      endcase
      st_next  = st_cur;
      key_next = key_offset_ff;
      done     = 1'b0;
      tail     = 1'b0;
      unique case (cls)
         CLS_SPACE: begin
            if (st_cur == ST_KEY) begin
               st_next = ST_PRE;
            end else if (st_cur == ST_VALUE) begin
               done = 1'b1;
            end
         end
         CLS_EQUAL: begin
            if (st_cur == ST_KEY || st_cur == ST_PRE) begin
               st_next = ST_ASSIGN;
            end else if (st_cur == ST_ASSIGN || st_cur == ST_VALUE) begin
               st_next = ST_INVALID;
            end
         end
         CLS_QUOTE: begin
            if (st_cur == ST_STRING) begin
               done = 1'b1;
               tail = 1'b1;
            end else if (st_cur == ST_KEY || st_cur == ST_PRE || st_cur == ST_VALUE) begin
               st_next = ST_INVALID;
            end else if (st_cur == ST_ASSIGN) begin
               st_next = ST_STRING;
            end
         end
         default: begin
            if (st_cur == ST_INVALID) begin
               st_next  = ST_KEY;
               key_next = char_index_ff;
            end else if (st_cur == ST_PRE) begin
               st_next = ST_INVALID;
            end else if (st_cur == ST_ASSIGN) begin
               st_next = ST_VALUE;
            end
         end
      endcase
      if (done) begin
         st_next = ST_INVALID;
      end
      // Pending bare value is flushed at the end of the buffer
      has = done || (last_char && st_next == ST_VALUE);
   end

   // Event toward the back end
   always_comb begin
      ev_push              = in_accept && (has || last_char);
      ev_flags.has_span    = has;
      ev_flags.end_of_list = last_char;
      ev_start_off         = key_next;
      ev_end_off           = {1'b0, char_index_ff} + {{IDX_W{1'b0}}, tail};
   end

   // Next register values; the last character restarts the scan
   always_comb begin
      state_in      = state_ff;
      key_offset_in = key_offset_ff;
      char_index_in = char_index_ff;
      if (in_accept) begin
         if (last_char) begin
            state_in      = ST_INVALID;
            key_offset_in = '0;
            char_index_in = '0;
         end else begin
            state_in      = st_next;
            key_offset_in = key_next;
            if (char_index_ff < IDX_LIMIT) begin
               char_index_in = char_index_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INVALID;
         key_offset_ff <= '0;
         char_index_ff <= '0;
      end else begin
         state_ff      <= state_in;
         key_offset_ff <= key_offset_in;
         char_index_ff <= char_index_in;
      end
   end

   `ASSERT_ALWAYS(a_index_bounded, clock, reset, char_index_ff <= IDX_LIMIT)
   `ASSERT_NEXT(a_last_restarts, clock, reset, in_accept && last_char, char_index_ff == '0 && key_offset_ff == '0 && state_ff == ST_INVALID)

endmodule

`default_nettype wire

[sv/xasp_queue.sv]
// Short event queue between the front and back ends.
`default_nettype none
`include "assert_macros.svh"

module xasp_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  valid,
   output logic [WIDTH-1:0]      head_data
);
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign valid     = (count_ff != '0);
   assign head_data = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_ALWAYS(a_count_bounded, clock, reset, count_ff <= CNT_FULL)

endmodule

`default_nettype wire

[sv/xasp_back.sv]
// Back end: absolute span positions with saturation and the result register.
`default_nettype none
`include "assert_macros.svh"

module xasp_back #(
   parameter int unsigned IDX_W = 12
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             ev_valid,
   input  wire xasp_pkg::span_flags_type         ev_flags,
   input  wire logic [IDX_W-1:0]                 ev_start_off,
   input  wire logic [IDX_W:0]                   ev_end_off,
   input  wire logic [xasp_pkg::POS_W-1:0]       ev_base,
   output logic                                  ev_pop,
   output logic                                  rsp_empty,
   input  wire logic                             rsp_pop,
   output logic                                  rsp_has_span,
   output logic [xasp_pkg::POS_W-1:0]            rsp_span_start,
   output logic [xasp_pkg::POS_W-1:0]            rsp_span_end,
   output logic                                  rsp_end_of_list
);
   import xasp_pkg::*;

   logic              valid_ff, valid_in;
   span_flags_type    flags_ff;
   logic [POS_W-1:0]  start_ff, start_in, end_ff, end_in;
   logic [POS_W:0]    start_sum, end_sum;

   // Saturating position adders
   always_comb begin
      start_sum = {1'b0, ev_base} + {{(POS_W + 1 - IDX_W){1'b0}}, ev_start_off};
      end_sum   = {1'b0, ev_base} + {{(POS_W - IDX_W){1'b0}}, ev_end_off};
      start_in  = '0;
      end_in    = '0;
      if (ev_flags.has_span) begin
         start_in = start_sum[POS_W] ? POS_MAX : start_sum[POS_W-1:0];
         end_in   = end_sum[POS_W] ? POS_MAX : end_sum[POS_W-1:0];
      end
   end

   // Output register refills whenever it is free or being drained
   assign ev_pop = ev_valid && (!valid_ff || rsp_pop);

   always_comb begin
      valid_in = valid_ff;
      if (ev_pop) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ev_pop) begin
         flags_ff <= ev_flags;
         start_ff <= start_in;
         end_ff   <= end_in;
      end
   end

   assign rsp_empty       = !valid_ff;
   assign rsp_has_span    = flags_ff.has_span;
   assign rsp_span_start  = start_ff;
   assign rsp_span_end    = end_ff;
   assign rsp_end_of_list = flags_ff.end_of_list;

   `ASSERT_IMPLIES(a_span_ordered, clock, reset, valid_ff && flags_ff.has_span, end_ff >= start_ff)

endmodule

`default_nettype wire
